### src/mdg_pkg.sv
// package for the motor drive deadzone gate: fixed point constants,
// register codes and the item structs of both channels
// no dependencies
`timescale 1ns / 1ps

package mdg_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int LEVEL_W   = 16;
  localparam int MAG_W     = LEVEL_W + 1;
  localparam int DUTY_W    = FRAC_BITS + 1;
  localparam int DZ_W      = FRAC_BITS;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = DUTY_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [DUTY_W-1:0] ONE_Q    = DUTY_W'(ONE);
  localparam logic [DZ_W-1:0]   DZ_MAX   = DZ_W'(ONE / 2);
  localparam logic [DZ_W-1:0]   DZ_RESET = DZ_W'((ONE * 5 + 50) / 100);

  // serial divider step count
  localparam int DIV_CNT_W = $clog2(FRAC_BITS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_BITS - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING = 2'd2;

  // item kinds
  localparam logic KIND_UPDATE    = 1'b0;
  localparam logic KIND_FORCE_OFF = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic signed [LEVEL_W-1:0] command_level;
    logic                      safety_good;
  } in_item_t;

  typedef struct packed {
    logic              motor_enable;
    logic              direction_positive;
    logic [DUTY_W-1:0] duty;
    logic              blocked;
    logic              stop_pulse;
    logic [CNT_W-1:0]  updates_seen;
    logic [CNT_W-1:0]  outputs_driven;
    logic [CNT_W-1:0]  safety_blocks;
  } out_item_t;

endpackage

### src/mdg_div_serial.sv
// restoring divider, one quotient bit per cycle
// dividend is rem_init << FRAC_BITS with rem_init below divisor; uses mdg_pkg
`timescale 1ns / 1ps

module mdg_div_serial (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [mdg_pkg::DUTY_W-1:0]        rem_init,
  input  logic [mdg_pkg::DUTY_W-1:0]        divisor,
  output logic                              done,
  output logic [mdg_pkg::FRAC_BITS-1:0]     quotient
);

  logic                             busy;
  logic [mdg_pkg::DIV_CNT_W-1:0]    step;
  logic [mdg_pkg::DUTY_W-1:0]       rem;
  logic [mdg_pkg::DUTY_W-1:0]       dvs;
  logic [mdg_pkg::DUTY_W:0]         shifted;
  logic                             fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= rem_init;
        dvs  <= divisor;
      end else if (busy) begin
        // remainder stays below the divisor, so it fits back in DUTY_W bits
        rem      <= fits ? mdg_pkg::DUTY_W'(shifted - {1'b0, dvs})
                         : shifted[mdg_pkg::DUTY_W-1:0];
        quotient <= {quotient[mdg_pkg::FRAC_BITS-2:0], fits};
        step     <= step + 1'b1;
        if (step == mdg_pkg::DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/motor_drive_deadzone_gate.sv
// force-off, refused or in-deadzone items and remaps that saturate go from accept
// straight to S_FIN; remaps that divide pass through S_DIV while the serial
// divider runs its 14 steps, then S_FIN. one item at a time; the next item is taken
// the cycle after its predecessor's result is loaded, while that result waits.
// reset (synchronous, active high): direction flag clear, no output valid,
// counters zero, deadzone 819, duty floor 0, duty ceiling full scale.
`timescale 1ns / 1ps

module motor_drive_deadzone_gate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mdg_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mdg_pkg::out_item_t                out_data,
  input  logic                              cfg_write,
  input  logic [mdg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mdg_pkg::CFG_W-1:0]         cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

  state_t state;

  // configuration
  logic [mdg_pkg::DZ_W-1:0]   deadzone;
  logic [mdg_pkg::DUTY_W-1:0] duty_floor;
  logic [mdg_pkg::DUTY_W-1:0] duty_ceiling;

  // persistent drive state
  logic                      direction_flag;
  logic [mdg_pkg::CNT_W-1:0] update_counter;
  logic [mdg_pkg::CNT_W-1:0] drive_counter;
  logic [mdg_pkg::CNT_W-1:0] block_counter;

  // item held while it is worked on
  logic                        item_kind;
  logic                        item_safe;
  logic                        item_neg;
  logic [mdg_pkg::DUTY_W-1:0]  item_res;

  logic                                accept;
  logic [mdg_pkg::MAG_W-1:0]           raw;
  logic [mdg_pkg::MAG_W-1:0]           mag;
  logic [mdg_pkg::MAG_W-1:0]           over;
  logic [mdg_pkg::DUTY_W-1:0]          span;
  logic                                in_zone;
  logic                                saturates;
  logic                                div_start;
  logic                                div_done;
  logic [mdg_pkg::FRAC_BITS-1:0]       quotient;
  logic                                out_free;
  logic [mdg_pkg::DUTY_W-1:0]          duty_clamped;
  logic [mdg_pkg::DZ_W-1:0]            cfg_dz;
  logic [mdg_pkg::DUTY_W-1:0]          cfg_duty;
  logic                                dir_pos;
  mdg_pkg::out_item_t                  fin_item;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // magnitude of the command, full negative gives 2**15
  assign raw  = {1'b0, in_data.command_level};
  assign mag  = raw[mdg_pkg::LEVEL_W-1]
                ? ({1'b1, {mdg_pkg::LEVEL_W{1'b0}}} - raw) : raw;
  assign over = mag - {{(mdg_pkg::MAG_W - mdg_pkg::DZ_W){1'b0}}, deadzone};
  assign span = mdg_pkg::ONE_Q - {1'b0, deadzone};
  assign in_zone = mag < {{(mdg_pkg::MAG_W - mdg_pkg::DZ_W){1'b0}}, deadzone};
  // quotient reaches one exactly when the excess reaches the span
  assign saturates = over >= {{(mdg_pkg::MAG_W - mdg_pkg::DUTY_W){1'b0}}, span};

  assign div_start = accept && (in_data.kind == mdg_pkg::KIND_UPDATE)
                     && in_data.safety_good && !in_zone && !saturates;

  mdg_div_serial u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (over[mdg_pkg::DUTY_W-1:0]),
    .divisor  (span),
    .done     (div_done),
    .quotient (quotient)
  );

  // floor is checked first: below the floor gives the floor, else above the ceiling gives the ceiling
  always_comb begin
    if (item_res < duty_floor) begin
      duty_clamped = duty_floor;
    end else if (item_res > duty_ceiling) begin
      duty_clamped = duty_ceiling;
    end else begin
      duty_clamped = item_res;
    end
  end

  // a remap that truncates to zero counts as nonnegative
  assign dir_pos = !(item_neg && (item_res != '0));

  // result of the finishing item, also the next drive state
  always_comb begin
    fin_item                    = '0;
    fin_item.direction_positive = direction_flag;
    fin_item.blocked            = 1'b1;
    fin_item.updates_seen       = update_counter;
    fin_item.outputs_driven     = drive_counter;
    fin_item.safety_blocks      = block_counter;
    if (item_kind == mdg_pkg::KIND_FORCE_OFF) begin
      fin_item.direction_positive = 1'b0;
      fin_item.stop_pulse         = 1'b1;
    end else if (!item_safe) begin
      fin_item.updates_seen  = update_counter + 1'b1;
      fin_item.safety_blocks = block_counter + 1'b1;
    end else begin
      fin_item.motor_enable       = 1'b1;
      fin_item.direction_positive = dir_pos;
      fin_item.duty               = duty_clamped;
      fin_item.blocked            = 1'b0;
      fin_item.updates_seen       = update_counter + 1'b1;
      fin_item.outputs_driven     = drive_counter + 1'b1;
    end
  end

  assign cfg_dz   = (cfg_data[mdg_pkg::DZ_W-1:0] > mdg_pkg::DZ_MAX)
                    ? mdg_pkg::DZ_MAX : cfg_data[mdg_pkg::DZ_W-1:0];
  assign cfg_duty = (cfg_data > mdg_pkg::ONE_Q) ? mdg_pkg::ONE_Q : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone     <= mdg_pkg::DZ_RESET;
      duty_floor   <= '0;
      duty_ceiling <= mdg_pkg::ONE_Q;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mdg_pkg::CFG_DEADZONE:     deadzone     <= cfg_dz;
        mdg_pkg::CFG_DUTY_FLOOR:   duty_floor   <= cfg_duty;
        mdg_pkg::CFG_DUTY_CEILING: duty_ceiling <= cfg_duty;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      direction_flag <= 1'b0;
      update_counter <= '0;
      drive_counter  <= '0;
      block_counter  <= '0;
    end else begin
      out_valid <= ((state == S_FIN) && out_free) || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_kind <= in_data.kind;
            item_safe <= in_data.safety_good;
            item_neg  <= in_data.command_level[mdg_pkg::LEVEL_W-1];
            item_res  <= in_zone ? '0 : mdg_pkg::ONE_Q;
            state     <= div_start ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            item_res <= {1'b0, quotient};
            state    <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state          <= S_IDLE;
            out_data       <= fin_item;
            direction_flag <= fin_item.direction_positive;
            update_counter <= fin_item.updates_seen;
            drive_counter  <= fin_item.outputs_driven;
            block_counter  <= fin_item.safety_blocks;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/tb_top.sv
// testbench for motor_drive_deadzone_gate: directed and random command items
// checked field by field against an in-bench predictor of the drive stage
// depends on mdg_pkg and the motor_drive_deadzone_gate rtl
`timescale 1ns / 1ps

module tb_top;

  // index past the last register, writes to it must be ignored
  localparam logic [mdg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  mdg_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  mdg_pkg::out_item_t out_data;
  logic cfg_write;
  logic [mdg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mdg_pkg::CFG_W-1:0] cfg_data;

  // predictor copy of the registers and state
  int dz_reg = int'(mdg_pkg::DZ_RESET);
  int floor_reg = 0;
  int ceil_reg = mdg_pkg::ONE;
  logic blocked_st = 1'b1;
  logic enabled_st = 1'b0;
  logic dir_st = 1'b0;
  int level_st = 0;
  logic [mdg_pkg::CNT_W-1:0] update_cnt = '0;
  logic [mdg_pkg::CNT_W-1:0] drive_cnt = '0;
  logic [mdg_pkg::CNT_W-1:0] block_cnt = '0;

  mdg_pkg::out_item_t expected_drive[$];
  mdg_pkg::out_item_t want;
  int mismatches = 0;
  bit idle_on = 1'b1;

  motor_drive_deadzone_gate uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic mdg_pkg::out_item_t predict_drive(input mdg_pkg::in_item_t it);
    mdg_pkg::out_item_t r;
    int lvl;
    int mag;
    int res;
    logic stop;
    stop = 1'b0;
    if (it.kind == mdg_pkg::KIND_FORCE_OFF) begin
      enabled_st = 1'b0;
      level_st = 0;
      dir_st = 1'b0;
      blocked_st = 1'b1;
      stop = 1'b1;
    end else begin
      update_cnt++;
      if (!it.safety_good) begin
        blocked_st = 1'b1;
        enabled_st = 1'b0;
        level_st = 0;
        block_cnt++;
      end else begin
        lvl = int'(it.command_level);
        mag = (lvl < 0) ? -lvl : lvl;
        blocked_st = 1'b0;
        if (mag < dz_reg) begin
          res = 0;
        end else begin
          res = ((mag - dz_reg) << mdg_pkg::FRAC_BITS) / (mdg_pkg::ONE - dz_reg);
        end
        if (res > mdg_pkg::ONE) res = mdg_pkg::ONE;
        level_st = (lvl < 0) ? -res : res;
        // a negative command that remaps to zero still counts as nonnegative
        dir_st = (level_st >= 0);
        enabled_st = 1'b1;
      end
    end
    r.duty = '0;
    if (enabled_st && !blocked_st) begin
      mag = (level_st < 0) ? -level_st : level_st;
      // floor is checked first, so below the floor gives the floor even when they cross
      if (mag < floor_reg) mag = floor_reg;
      else if (mag > ceil_reg) mag = ceil_reg;
      r.duty = mdg_pkg::DUTY_W'(mag);
      drive_cnt++;
    end
    r.motor_enable = enabled_st && !blocked_st;
    r.direction_positive = dir_st;
    r.blocked = blocked_st;
    r.stop_pulse = stop;
    r.updates_seen = update_cnt;
    r.outputs_driven = drive_cnt;
    r.safety_blocks = block_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got_v,
                                 input longint unsigned want_v);
    $display("mismatch %s: got %0d expected %0d", what, got_v, want_v);
    mismatches++;
  endtask

  task automatic write_reg(input logic [mdg_pkg::CFG_IDX_W-1:0] idx, input int value);
    logic [mdg_pkg::CFG_W-1:0] v;
    v = mdg_pkg::CFG_W'(value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      mdg_pkg::CFG_DEADZONE: begin
        dz_reg = int'(v[mdg_pkg::DZ_W-1:0]);
        if (dz_reg > mdg_pkg::ONE / 2) dz_reg = mdg_pkg::ONE / 2;
      end
      mdg_pkg::CFG_DUTY_FLOOR: begin
        floor_reg = int'(v);
        if (floor_reg > mdg_pkg::ONE) floor_reg = mdg_pkg::ONE;
      end
      mdg_pkg::CFG_DUTY_CEILING: begin
        ceil_reg = int'(v);
        if (ceil_reg > mdg_pkg::ONE) ceil_reg = mdg_pkg::ONE;
      end
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic kind, input int level, input logic safe);
    mdg_pkg::in_item_t it;
    it.kind = kind;
    it.command_level = mdg_pkg::LEVEL_W'(level);
    it.safety_good = safe;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(posedge clk);
    end while (in_stall);
    expected_drive.push_back(predict_drive(it));
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_drive.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    // covers the longest divide before anything else happens
    repeat (20) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_item(mdg_pkg::KIND_FORCE_OFF, 1234, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, 5000, 1'b0);
    send_item(mdg_pkg::KIND_UPDATE, mdg_pkg::ONE, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, -mdg_pkg::ONE, 1'b1);
    // refused item keeps the negative direction
    send_item(mdg_pkg::KIND_UPDATE, 3000, 1'b0);
    send_item(mdg_pkg::KIND_UPDATE, 32767, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, -32768, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, 0, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, int'(mdg_pkg::DZ_RESET) - 1, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, int'(mdg_pkg::DZ_RESET), 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, -int'(mdg_pkg::DZ_RESET), 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, -int'(mdg_pkg::DZ_RESET) - 1, 1'b1);
    wait_drained();
  endtask

  task automatic test_deadzone_limits();
    write_reg(mdg_pkg::CFG_DEADZONE, 0);
    send_item(mdg_pkg::KIND_UPDATE, 5000, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, -20000, 1'b1);
    wait_drained();
    // above half scale saturates
    write_reg(mdg_pkg::CFG_DEADZONE, 'h7FFF);
    send_item(mdg_pkg::KIND_UPDATE, 8191, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, -12000, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, mdg_pkg::ONE, 1'b1);
    wait_drained();
    // upper bit beyond the register width is dropped
    write_reg(mdg_pkg::CFG_DEADZONE, 'h4000);
    write_reg(CFG_UNUSED, 'h7FFF);
    send_item(mdg_pkg::KIND_UPDATE, 100, 1'b1);
    wait_drained();
  endtask

  task automatic test_duty_limits();
    write_reg(mdg_pkg::CFG_DUTY_FLOOR, 12000);
    write_reg(mdg_pkg::CFG_DUTY_CEILING, 4000);
    send_item(mdg_pkg::KIND_UPDATE, 100, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, -mdg_pkg::ONE, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, 8000, 1'b1);
    wait_drained();
    write_reg(mdg_pkg::CFG_DUTY_FLOOR, 'h7FFF);
    write_reg(mdg_pkg::CFG_DUTY_CEILING, 'h7FFF);
    send_item(mdg_pkg::KIND_UPDATE, 1, 1'b1);
    send_item(mdg_pkg::KIND_UPDATE, 1, 1'b0);
    send_item(mdg_pkg::KIND_FORCE_OFF, -1, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int level;
    int pick;
    for (int p = 0; p < 13; p++) begin
      if (p == 0) begin
        write_reg(mdg_pkg::CFG_DEADZONE, 0);
        write_reg(mdg_pkg::CFG_DUTY_FLOOR, 0);
        write_reg(mdg_pkg::CFG_DUTY_CEILING, mdg_pkg::ONE);
      end else if (p == 1) begin
        write_reg(mdg_pkg::CFG_DEADZONE, mdg_pkg::ONE / 2);
        write_reg(mdg_pkg::CFG_DUTY_FLOOR, mdg_pkg::ONE);
        write_reg(mdg_pkg::CFG_DUTY_CEILING, 0);
      end else begin
        write_reg(mdg_pkg::CFG_DEADZONE, ($urandom_range(0, 3) == 0) ?
                  $urandom_range(0, 32767) : $urandom_range(0, mdg_pkg::ONE / 2));
        write_reg(mdg_pkg::CFG_DUTY_FLOOR, ($urandom_range(0, 3) == 0) ?
                  $urandom_range(0, 32767) : $urandom_range(0, 2000));
        write_reg(mdg_pkg::CFG_DUTY_CEILING, ($urandom_range(0, 3) == 0) ?
                  $urandom_range(0, 32767) : $urandom_range(10000, mdg_pkg::ONE));
        write_reg(CFG_UNUSED, $urandom_range(0, 32767));
      end
      // quiet phases and a quiet tail
      idle_on = (p != 12) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++) begin
        case ($urandom_range(0, 3))
          0: level = $urandom_range(0, 65535);
          1: level = dz_reg + int'($urandom_range(0, 6)) - 3;
          2: level = mdg_pkg::ONE + int'($urandom_range(0, 40)) - 20;
          default: level = $urandom_range(0, dz_reg + 200);
        endcase
        if ($urandom_range(0, 1) == 1) level = -level;
        pick = $urandom_range(0, 99);
        if (pick < 6) send_item(mdg_pkg::KIND_FORCE_OFF, level, 1'($urandom_range(0, 1)));
        else if (pick < 14) send_item(mdg_pkg::KIND_UPDATE, level, 1'b0);
        else send_item(mdg_pkg::KIND_UPDATE, level, 1'b1);
      end
      wait_drained();
    end
  endtask

  // receiver side stall bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_drive.size() == 0) begin
        report_mismatch("item with nothing expected", 64'(out_data.updates_seen), 64'd0);
      end else begin
        want = expected_drive.pop_front();
        if (out_data.motor_enable !== want.motor_enable)
          report_mismatch("motor_enable", 64'(out_data.motor_enable),
                          64'(want.motor_enable));
        if (out_data.direction_positive !== want.direction_positive)
          report_mismatch("direction_positive", 64'(out_data.direction_positive),
                          64'(want.direction_positive));
        if (out_data.duty !== want.duty)
          report_mismatch("duty", 64'(out_data.duty), 64'(want.duty));
        if (out_data.blocked !== want.blocked)
          report_mismatch("blocked", 64'(out_data.blocked), 64'(want.blocked));
        if (out_data.stop_pulse !== want.stop_pulse)
          report_mismatch("stop_pulse", 64'(out_data.stop_pulse), 64'(want.stop_pulse));
        if (out_data.updates_seen !== want.updates_seen)
          report_mismatch("updates_seen", 64'(out_data.updates_seen),
                          64'(want.updates_seen));
        if (out_data.outputs_driven !== want.outputs_driven)
          report_mismatch("outputs_driven", 64'(out_data.outputs_driven),
                          64'(want.outputs_driven));
        if (out_data.safety_blocks !== want.safety_blocks)
          report_mismatch("safety_blocks", 64'(out_data.safety_blocks),
                          64'(want.safety_blocks));
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_deadzone_limits();
    test_duty_limits();
    test_random_traffic();
    if (expected_drive.size() != 0) begin
      report_mismatch("items never delivered", 64'd0, 64'(expected_drive.size()));
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
src/mdg_pkg.sv
src/mdg_div_serial.sv
src/motor_drive_deadzone_gate.sv
tb/tb_top.sv
